// File: src/frl_pkg.sv
// ----------------------------------------------------------------------------
// frl_pkg
// Shared types and constants of the fixed-window rate limiter.
// ----------------------------------------------------------------------------
package frl_pkg;

  localparam int unsigned ENTRIES     = 256;
  localparam int unsigned KINDS       = 5;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned ROUND_UP_US = 999;
  localparam int unsigned DIV_W       = 64;
  localparam int unsigned DVSR_W      = 42;
  localparam int unsigned CNT_W       = 7;

  // The retry time is (x >> 3) / 125, worked one byte per cycle, each digit
  // found by a reciprocal multiplication.
  localparam int unsigned RET_DIGITS  = 5;
  localparam int unsigned RET_DIV     = 125;
  localparam int unsigned RET_RECIP   = 33555;
  localparam int unsigned RET_SHIFT   = 22;

  typedef struct packed {
    logic [63:0] window_begin;
    logic [31:0] used_count;
    logic [31:0] rejected_count;
  } mem_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LOAD,
    ST_DIV1,
    ST_CHECK,
    ST_DIV2,
    ST_FIN
  } state_e;

endpackage

// File: src/frl_if.sv
// ----------------------------------------------------------------------------
// frl_req_if / frl_rsp_if
// Request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface frl_req_if;
  logic                valid;
  logic                ready;
  logic [7:0]          entry_index;
  logic                slot_found;
  logic                new_entry;
  logic [2:0]          kind;
  logic [62:0]         now_us;
  logic signed [31:0]  limit_count;
  logic signed [31:0]  win_len_ms;

  modport source (output valid, entry_index, slot_found, new_entry, kind, now_us,
                  limit_count, win_len_ms, input ready);
  modport sink (input valid, entry_index, slot_found, new_entry, kind, now_us,
                limit_count, win_len_ms, output ready);
endinterface

interface frl_rsp_if;
  logic        valid;
  logic        ready;
  logic        allowed;
  logic [30:0] retry_ms;

  modport source (output valid, allowed, retry_ms, input ready);
  modport sink (input valid, allowed, retry_ms, output ready);
endinterface

// File: src/frl_div.sv
// ----------------------------------------------------------------------------
// frl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [frl_pkg::DIV_W-1:0]  dividend_i,
  input  logic [frl_pkg::DVSR_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [frl_pkg::DVSR_W-1:0] rem_o
);

  logic [frl_pkg::DVSR_W:0]   rem_q, rem_d, trial;
  logic [frl_pkg::DIV_W-1:0]  q_q, q_d;
  logic [frl_pkg::DVSR_W-1:0] dvsr_q;
  logic [frl_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic                       fits;

  always_comb begin
    trial  = {rem_q[frl_pkg::DVSR_W-1:0], q_q[frl_pkg::DIV_W-1]};
    fits   = trial >= {1'b0, dvsr_q};
    rem_d  = rem_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      q_d    = dividend_i;
      cnt_d  = frl_pkg::CNT_W'(frl_pkg::DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial - {1'b0, dvsr_q} : trial;
      q_d   = {q_q[frl_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q - frl_pkg::CNT_W'(1);
      if (cnt_q == frl_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    if (start_i) begin
      dvsr_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[frl_pkg::DVSR_W-1:0];

endmodule

// File: src/fixed_window_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// fixed_window_rate_limiter_top
// Table of fixed-window rate counters held in one synchronous memory.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// req_i    in   entry_index, slot_found, new_entry, kind, now_us, limit, window
// rsp_o    out  allowed, retry_ms
//
// A request whose limit or window is disabled, whose kind is bad or that has no slot
// goes straight to the result. Any other reads its entry and checks it, runs the
// bit-serial divider first when the window has expired, and the byte-wise division
// of the retry time when it is rejected.
// One request is worked on at a time; a new one is taken while a result waits.
// Reset clears control state only; the table is undefined until written.
module fixed_window_rate_limiter_top (
  input logic      clk_i,
  input logic      rst_ni,
  frl_req_if.sink  req_i,
  frl_rsp_if.source rsp_o
);

  frl_pkg::state_e state_q, state_d;

  logic [frl_pkg::IDX_W-1:0]  idx_q;
  logic                       fresh_q;
  logic [63:0]                now_q;
  logic [31:0]                limit_q;
  logic [30:0]                win_q;
  logic [frl_pkg::DVSR_W-1:0] wus_q;
  logic [63:0]                wus999_q;
  logic [63:0]                begin_q;
  logic [31:0]                used_q, rej_q;
  frl_pkg::mem_word_t         mem_q [frl_pkg::ENTRIES];
  frl_pkg::mem_word_t         rdata_q, wdata;
  logic                       res_allow_q;
  logic [30:0]                res_retry_q;
  logic                       out_valid_q, out_allow_q;
  logic [30:0]                out_retry_q;
  logic [39:0]                dig_src_q;
  logic [6:0]                 dig_rem_q;
  logic [23:0]                dig_quot_q;
  logic [2:0]                 dig_cnt_q;

  logic                       accept, fast, out_free, allow_now;
  logic                       mem_we, div_start, out_load;
  logic [63:0]                begin_eff, elapsed, ret_x;
  logic [31:0]                used_eff, rej_eff;
  logic                       div_done;
  logic [frl_pkg::DIV_W-1:0]  div_dvd;
  logic [frl_pkg::DVSR_W-1:0] div_rem, div_dvsr;
  logic [14:0]                dig_t, dig_back;
  logic [30:0]                dig_prod;
  logic [7:0]                 dig_q;
  logic                       dig_last;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign fast = req_i.limit_count[31] || (req_i.limit_count == 32'sd0)
             || req_i.win_len_ms[31] || (req_i.win_len_ms == 32'sd0)
             || ({1'b0, req_i.kind} >= 4'(frl_pkg::KINDS))
             || !req_i.slot_found
             || ({1'b0, req_i.entry_index} >= 9'(frl_pkg::ENTRIES));

  always_comb begin
    begin_eff = fresh_q ? now_q : rdata_q.window_begin;
    used_eff  = fresh_q ? 32'd0 : rdata_q.used_count;
    rej_eff   = fresh_q ? 32'd0 : rdata_q.rejected_count;
    elapsed   = now_q - begin_eff;
    allow_now = used_q < limit_q;
    wdata.window_begin   = begin_q;
    wdata.used_count     = allow_now ? used_q + 32'd1 : used_q;
    wdata.rejected_count = allow_now ? rej_q : rej_q + 32'd1;
    div_dvd  = elapsed;
    div_dvsr = wus_q;
    ret_x    = begin_q - now_q + wus999_q;
    dig_t    = {dig_rem_q, dig_src_q[39:32]};
    dig_prod = 31'(dig_t) * 31'(frl_pkg::RET_RECIP);
    dig_q    = 8'(dig_prod >> frl_pkg::RET_SHIFT);
    dig_back = dig_t - 15'(dig_q) * 15'(frl_pkg::RET_DIV);
    dig_last = dig_cnt_q == 3'd1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frl_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = fast ? frl_pkg::ST_FIN : frl_pkg::ST_RD;
        end
      end
      frl_pkg::ST_RD:   state_d = frl_pkg::ST_LOAD;
      frl_pkg::ST_LOAD: begin
        if (now_q < begin_eff) begin
          state_d = frl_pkg::ST_CHECK;
        end else if (elapsed >= 64'(wus_q)) begin
          state_d = frl_pkg::ST_DIV1;
        end else begin
          state_d = frl_pkg::ST_CHECK;
        end
      end
      frl_pkg::ST_DIV1: begin
        if (div_done) begin
          state_d = frl_pkg::ST_CHECK;
        end
      end
      frl_pkg::ST_CHECK: state_d = allow_now ? frl_pkg::ST_FIN : frl_pkg::ST_DIV2;
      frl_pkg::ST_DIV2: begin
        if (dig_last) begin
          state_d = frl_pkg::ST_FIN;
        end
      end
      frl_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = frl_pkg::ST_IDLE;
        end
      end
      default: state_d = frl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      frl_pkg::ST_IDLE:  req_i.ready = 1'b1;
      frl_pkg::ST_LOAD:  div_start = (now_q >= begin_eff) && (elapsed >= 64'(wus_q));
      frl_pkg::ST_CHECK: mem_we = 1'b1;
      frl_pkg::ST_FIN:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q       <= req_i.entry_index;
      fresh_q     <= req_i.new_entry;
      now_q       <= {1'b0, req_i.now_us};
      limit_q     <= req_i.limit_count;
      win_q       <= req_i.win_len_ms[30:0];
      res_allow_q <= 1'b1;
      res_retry_q <= '0;
    end
    if (state_q == frl_pkg::ST_RD) begin
      wus_q <= frl_pkg::DVSR_W'(win_q) * frl_pkg::DVSR_W'(frl_pkg::US_PER_MS);
    end
    if (state_q == frl_pkg::ST_LOAD) begin
      wus999_q <= 64'(wus_q) + 64'(frl_pkg::ROUND_UP_US);
      rej_q    <= rej_eff;
      if (now_q < begin_eff) begin
        begin_q <= now_q;
        used_q  <= '0;
      end else begin
        begin_q <= begin_eff;
        used_q  <= (elapsed >= 64'(wus_q)) ? 32'd0 : used_eff;
      end
    end
    if (state_q == frl_pkg::ST_DIV1 && div_done) begin
      begin_q <= now_q - 64'(div_rem);
    end
    if (state_q == frl_pkg::ST_CHECK) begin
      res_allow_q <= allow_now;
      dig_src_q   <= ret_x[42:3];
      dig_rem_q   <= '0;
      dig_cnt_q   <= 3'(frl_pkg::RET_DIGITS);
    end
    if (state_q == frl_pkg::ST_DIV2) begin
      dig_src_q  <= {dig_src_q[31:0], 8'd0};
      dig_rem_q  <= dig_back[6:0];
      dig_quot_q <= {dig_quot_q[15:0], dig_q};
      dig_cnt_q  <= dig_cnt_q - 3'd1;
      if (dig_last) begin
        res_retry_q <= {dig_quot_q[22:0], dig_q};
      end
    end
    if (out_load) begin
      out_allow_q <= res_allow_q;
      out_retry_q <= res_retry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= wdata;
    end
    rdata_q <= mem_q[idx_q];
  end

  frl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvsr),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.allowed  = out_allow_q;
  assign rsp_o.retry_ms = out_retry_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.allowed |-> rsp_o.retry_ms != 31'd0)
    else $error("Rejected result carries no retry time.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.allowed |-> rsp_o.retry_ms == 31'd0)
    else $error("Allowed result carries a retry time.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == frl_pkg::ST_DIV1)
    else $error("Divider finished outside the window divide state.");

endmodule
